[hw/rtl/h2d_pkg.sv]
package h2d_pkg;

    localparam int unsigned PREFACE_LEN = 24;
    localparam int unsigned PRIO_LEN    = 5;

    localparam logic [2:0] KIND_HEADER_BYTE = 3'd0;
    localparam logic [2:0] KIND_BODY_BYTE   = 3'd1;
    localparam logic [2:0] KIND_FRAME_END   = 3'd2;
    localparam logic [2:0] KIND_STREAM_RST  = 3'd3;
    localparam logic [2:0] KIND_PREFACE_BAD = 3'd4;

    localparam logic [7:0] FT_DATA     = 8'd0;
    localparam logic [7:0] FT_HEADERS  = 8'd1;
    localparam logic [7:0] FT_RST      = 8'd3;
    localparam logic [7:0] FT_SETTINGS = 8'd4;
    localparam logic [7:0] FT_GOAWAY   = 8'd7;
    localparam logic [7:0] FT_WINUPD   = 8'd8;
    localparam logic [7:0] FT_CONT     = 8'd9;

    localparam int unsigned FLAG_PADDED   = 3;
    localparam int unsigned FLAG_PRIORITY = 5;

    localparam logic       REG_EXPECT_PREFACE = 1'b0;
    localparam logic       REG_EMIT_BODY      = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  ftype;
        logic [7:0]  flags;
        logic [30:0] stream;
        logic        last;
    } t_result;

    typedef struct packed {
        logic expect_preface;
        logic emit_server_body;
    } t_cfg;

    function automatic logic [7:0] preface_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:  b = 8'h50;
            5'd1:  b = 8'h52;
            5'd2:  b = 8'h49;
            5'd3:  b = 8'h20;
            5'd4:  b = 8'h2a;
            5'd5:  b = 8'h20;
            5'd6:  b = 8'h48;
            5'd7:  b = 8'h54;
            5'd8:  b = 8'h54;
            5'd9:  b = 8'h50;
            5'd10: b = 8'h2f;
            5'd11: b = 8'h32;
            5'd12: b = 8'h2e;
            5'd13: b = 8'h30;
            5'd14: b = 8'h0d;
            5'd15: b = 8'h0a;
            5'd16: b = 8'h0d;
            5'd17: b = 8'h0a;
            5'd18: b = 8'h53;
            5'd19: b = 8'h4d;
            5'd20: b = 8'h0d;
            5'd21: b = 8'h0a;
            5'd22: b = 8'h0d;
            5'd23: b = 8'h0a;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/h2d_parser.sv]
module h2d_parser
    import h2d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [1:0] PH_PREFACE = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [4:0]  r_pidx, n_pidx;
    logic [3:0]  r_hcnt, n_hcnt;
    logic [23:0] r_len, n_len;
    logic [7:0]  r_ftype, n_ftype;
    logic [7:0]  r_flags, n_flags;
    logic [30:0] r_stream, n_stream;
    logic [23:0] r_pleft, n_pleft;
    logic [23:0] r_cleft, n_cleft;
    logic [2:0]  r_pskip, n_pskip;
    logic        r_drop, n_drop;
    logic        r_padp, n_padp;

    logic [1:0]  ph;
    logic [23:0] rest;
    logic [23:0] pad_content;
    logic        last;
    logic        fend;
    logic        body_ok;
    logic        hdr_prio;

    always_comb begin
        n_phase     = r_phase;
        n_pidx      = r_pidx;
        n_hcnt      = r_hcnt;
        n_len       = r_len;
        n_ftype     = r_ftype;
        n_flags     = r_flags;
        n_stream    = r_stream;
        n_pleft     = r_pleft;
        n_cleft     = r_cleft;
        n_pskip     = r_pskip;
        n_drop      = r_drop;
        n_padp      = r_padp;
        o_res_valid = 1'b0;
        o_res       = '0;
        fend        = 1'b0;
        last        = 1'b0;
        rest        = r_len - 24'd1;
        pad_content = (rest > {16'd0, i_byte}) ? rest - {16'd0, i_byte} : 24'd0;
        body_ok     = (r_ftype != FT_DATA) || i_cfg.expect_preface || i_cfg.emit_server_body;
        hdr_prio    = (r_ftype == FT_HEADERS) && r_flags[FLAG_PRIORITY];

        ph = r_phase;
        if (r_phase == PH_PREFACE && !i_cfg.expect_preface) begin
            ph     = PH_HEADER;
            n_pidx = '0;
        end

        case (ph)
            PH_PREFACE: begin
                if (r_pidx < 5'(PREFACE_LEN) && i_byte == preface_byte(r_pidx)) begin
                    n_pidx = r_pidx + 5'd1;
                    if (n_pidx == 5'(PREFACE_LEN)) begin
                        n_pidx  = '0;
                        n_phase = PH_HEADER;
                    end
                end else begin
                    n_phase     = PH_DISCARD;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PREFACE_BAD;
                end
            end
            PH_HEADER: begin
                n_phase = PH_HEADER;
                if (r_hcnt == 4'd0) begin
                    n_len = {16'd0, i_byte};
                end else if (r_hcnt < 4'd3) begin
                    n_len = {r_len[15:0], i_byte};
                end else if (r_hcnt == 4'd3) begin
                    n_ftype = i_byte;
                end else if (r_hcnt == 4'd4) begin
                    n_flags = i_byte;
                end else if (r_hcnt == 4'd5) begin
                    n_stream = {24'd0, i_byte[6:0]};
                end else begin
                    n_stream = {r_stream[22:0], i_byte};
                end
                if (r_hcnt < 4'd8) begin
                    n_hcnt = r_hcnt + 4'd1;
                end else begin
                    n_hcnt  = '0;
                    n_pleft = r_len;
                    n_cleft = '0;
                    n_pskip = '0;
                    n_padp  = 1'b0;
                    n_drop  = (n_stream == 31'd0) || r_ftype == FT_SETTINGS ||
                              r_ftype == FT_GOAWAY || r_ftype == FT_WINUPD;
                    if (!n_drop) begin
                        if ((r_ftype == FT_DATA || r_ftype == FT_HEADERS) &&
                            r_flags[FLAG_PADDED]) begin
                            if (r_len == 24'd0) begin
                                n_drop = 1'b1;
                            end else begin
                                n_padp = 1'b1;
                            end
                        end else if (r_ftype == FT_DATA || r_ftype == FT_HEADERS ||
                                     r_ftype == FT_CONT) begin
                            n_cleft = r_len;
                            if (hdr_prio) begin
                                if (r_len < 24'(PRIO_LEN)) begin
                                    n_drop = 1'b1;
                                end else begin
                                    n_pskip = 3'(PRIO_LEN);
                                    n_cleft = r_len - 24'(PRIO_LEN);
                                end
                            end
                        end
                    end
                    if (r_len == 24'd0) begin
                        fend = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pleft = r_pleft - 24'd1;
                last    = (n_pleft == 24'd0);
                fend    = last;
                if (r_drop) begin
                    n_drop = 1'b1;
                end else if (r_padp) begin
                    n_padp  = 1'b0;
                    n_cleft = pad_content;
                    if (hdr_prio) begin
                        if (pad_content < 24'(PRIO_LEN)) begin
                            n_drop = 1'b1;
                        end else begin
                            n_pskip = 3'(PRIO_LEN);
                            n_cleft = pad_content - 24'(PRIO_LEN);
                        end
                    end
                end else if (r_pskip != 3'd0) begin
                    n_pskip = r_pskip - 3'd1;
                end else if (r_cleft != 24'd0) begin
                    n_cleft = r_cleft - 24'd1;
                    if (body_ok) begin
                        fend         = 1'b0;
                        o_res_valid  = 1'b1;
                        o_res.kind   = (r_ftype == FT_DATA) ? KIND_BODY_BYTE : KIND_HEADER_BYTE;
                        o_res.data   = i_byte;
                        o_res.ftype  = r_ftype;
                        o_res.flags  = r_flags;
                        o_res.stream = r_stream;
                        o_res.last   = last;
                        if (last) begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_DISCARD;
            end
        endcase

        if (fend) begin
            n_phase = PH_HEADER;
            if (!n_drop) begin
                o_res_valid  = 1'b1;
                o_res.kind   = (n_ftype == FT_RST) ? KIND_STREAM_RST : KIND_FRAME_END;
                o_res.ftype  = n_ftype;
                o_res.flags  = n_flags;
                o_res.stream = n_stream;
                o_res.last   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PREFACE;
            r_pidx   <= '0;
            r_hcnt   <= '0;
            r_len    <= '0;
            r_ftype  <= '0;
            r_flags  <= '0;
            r_stream <= '0;
            r_pleft  <= '0;
            r_cleft  <= '0;
            r_pskip  <= '0;
            r_drop   <= 1'b0;
            r_padp   <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_pidx   <= n_pidx;
            r_hcnt   <= n_hcnt;
            r_len    <= n_len;
            r_ftype  <= n_ftype;
            r_flags  <= n_flags;
            r_stream <= n_stream;
            r_pleft  <= n_pleft;
            r_cleft  <= n_cleft;
            r_pskip  <= n_pskip;
            r_drop   <= n_drop;
            r_padp   <= n_padp;
        end
    end

endmodule

[hw/rtl/h2d_fifo.sv]
module h2d_fifo
    import h2d_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_result                    i_data,
    input  logic                       i_pop,
    output t_result                    o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/h2d_back.sv]
module h2d_back
    import h2d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_head,
    input  logic    i_empty,
    output logic    o_pop,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;
    logic    load;

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && !i_empty;
    assign n_valid = load ? !i_empty : r_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

endmodule

[hw/rtl/http2_frame_deframer.sv]
// A byte that yields a result is written into the result queue, then moves into the master-side output register.
// One byte per cycle is accepted while the result queue is not full; the parser updates on each accepted byte.
// The slave side stalls only when the result queue is full.
// Reset is synchronous and active low; it returns the parser to the preface check,
// empties the queue and restores the configuration registers to their defaults.
module http2_frame_deframer
    import h2d_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_byte, frame_type_out, frame_flags_out, stream_out
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_cfg          r_cfg;
    logic          take;
    logic          res_valid;
    t_result       res;
    t_result       head;
    t_result       out_res;
    logic          q_empty, q_full, q_pop;
    logic [CW-1:0] q_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EMIT_BODY) ? {31'd0, r_cfg.emit_server_body}
                                                : {31'd0, r_cfg.expect_preface};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expect_preface   <= 1'b1;
            r_cfg.emit_server_body <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_EXPECT_PREFACE) begin
                r_cfg.expect_preface <= pwdata[0];
            end else begin
                r_cfg.emit_server_body <= pwdata[0];
            end
        end
    end

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && s_axis_tready;

    h2d_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_take      (take),
        .i_byte      (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    h2d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take && res_valid),
        .i_data  (res),
        .i_pop   (q_pop),
        .o_data  (head),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    h2d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.stream, out_res.flags, out_res.ftype, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= KIND_PREFACE_BAD)
        else $error("result kind out of range");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FRAME_END || m_axis_tuser == KIND_STREAM_RST)
        |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
        else $error("frame end without last flag or with content");

    a_preface_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PREFACE_BAD
        |-> m_axis_tdata == 56'd0 && !m_axis_tlast)
        else $error("preface mismatch carries frame fields");

endmodule
